[hw/rtl/core_memory_parity_checker_top_assert.svh]
// assertion macros shared by the parity checker modules
`ifndef CORE_MEMORY_PARITY_CHECKER_TOP_ASSERT_SVH
`define CORE_MEMORY_PARITY_CHECKER_TOP_ASSERT_SVH

// condition must never be seen at a clock edge outside reset
`define CMPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define CMPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cmpc_pkg.sv]
package cmpc_pkg;

    localparam int MEM_DEPTH   = 32768;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int IN_ADDR_W   = 16;
    localparam int CAP_W       = 16;
    localparam int DATA_W      = 8;
    localparam int MEM_W       = DATA_W + 2;
    localparam int MARK_BIT    = DATA_W + 1;
    localparam int CHECK_BIT   = DATA_W;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'h8000;
    localparam logic [CAP_W:0]   DEPTH_LIMIT    = (CAP_W + 1)'(MEM_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_INSTALLED_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_ERROR_STOP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_BLANK_CELLS  = 2'd2;

    // classified access handed from front to back
    typedef struct packed {
        logic              op_write;
        logic              addr_ok;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic              check_bit;
        logic              check_blank;
        logic              inhibit;
    } mid_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              invalid_address_lamp;
        logic              memory_check_lamp;
        logic              stop_flag;
    } result_t;

    function automatic logic check_bit_of(input logic [DATA_W-1:0] value);
        check_bit_of = ~(^value);
    endfunction

endpackage

[hw/rtl/core_memory_parity_checker_top.sv]
// byte memory with odd parity check bit and a written mark per location
// input channel: an access (operation, address, write_data, force_check_bit,
// forced_bit_value) transfers at a clock edge with push high and full low
// result channel: the oldest result sits on read_data and the lamp outputs
// while empty is low; it transfers at an edge with pop high and empty low
// configuration: cfg_write_en writes register cfg_index (0 capacity, 1 stop inhibit,
// 2 blank checking) from cfg_write_data; the user writes only while idle, which the block does not enforce
// latency: a write or an invalid address passes the input queue and the result
// queue; a read also passes ST_READ, since the memory read port is registered
// throughput: one write or invalid access per cycle while the result queue has room;
// a read holds the next access back for its read-then-check pass through the memory port
// reset: lamps and stop flag clear; then the written marks are swept clear,
// one location a cycle over all 32768 locations, with full held high meanwhile
// stall: small queues sit between front, back and result port; a stalled
// receiver fills them and full rises, no result is lost
module core_memory_parity_checker_top import cmpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_write_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 operation,
    input  logic [IN_ADDR_W-1:0] address,
    input  logic [DATA_W-1:0]    write_data,
    input  logic                 force_check_bit,
    input  logic                 forced_bit_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [DATA_W-1:0]    read_data,
    output logic                 invalid_address_lamp,
    output logic                 memory_check_lamp,
    output logic                 stop_flag
);

    logic      queue_push;
    mid_item_t queue_item;
    logic      queue_full;
    logic      queue_empty;
    logic      queue_pop;
    mid_item_t head_item;
    logic      back_ready;
    result_t   out_item;

    cmpc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data),
        .push             (push),
        .operation        (operation),
        .address          (address),
        .write_data       (write_data),
        .force_check_bit  (force_check_bit),
        .forced_bit_value (forced_bit_value),
        .queue_full       (queue_full),
        .back_ready       (back_ready),
        .full             (full),
        .queue_push       (queue_push),
        .queue_item       (queue_item)
    );

    cmpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (queue_push),
        .push_item (queue_item),
        .full      (queue_full),
        .pop_en    (queue_pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    cmpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (queue_empty),
        .mid_item  (head_item),
        .mid_pop   (queue_pop),
        .ready     (back_ready),
        .out_pop   (pop && !empty),
        .out_empty (empty),
        .out_item  (out_item)
    );

    assign read_data            = out_item.read_data;
    assign invalid_address_lamp = out_item.invalid_address_lamp;
    assign memory_check_lamp    = out_item.memory_check_lamp;
    assign stop_flag            = out_item.stop_flag;

endmodule

[hw/rtl/cmpc_queue.sv]
`include "core_memory_parity_checker_top_assert.svh"

module cmpc_queue import cmpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  mid_item_t push_item,
    output logic      full,
    input  logic      pop_en,
    output mid_item_t head_item,
    output logic      empty
);

    mid_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `CMPC_ASSERT_NEVER(a_no_push_full, clk, rst_n, push_en && full, "push into full queue")
    `CMPC_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop_en && empty, "pop from empty queue")
    `CMPC_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, empty, wr_ptr_reg == rd_ptr_reg, "pointers apart while empty")

endmodule

[hw/rtl/cmpc_front.sv]
module cmpc_front import cmpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAP_W-1:0]     cfg_write_data,
    input  logic                 push,
    input  logic                 operation,
    input  logic [IN_ADDR_W-1:0] address,
    input  logic [DATA_W-1:0]    write_data,
    input  logic                 force_check_bit,
    input  logic                 forced_bit_value,
    input  logic                 queue_full,
    input  logic                 back_ready,
    output logic                 full,
    output logic                 queue_push,
    output mid_item_t            queue_item
);

    logic [CAP_W-1:0] capacity_reg;
    logic             inhibit_reg;
    logic             blank_reg;
    logic [CAP_W:0]   limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            inhibit_reg  <= 1'b0;
            blank_reg    <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_INSTALLED_CAPACITY: capacity_reg <= cfg_write_data;
                CFG_INHIBIT_ERROR_STOP: inhibit_reg  <= cfg_write_data[0];
                CFG_CHECK_BLANK_CELLS:  blank_reg    <= cfg_write_data[0];
                default:                ;
            endcase
        end
    end

    // zero capacity means the full build, larger values saturate
    always_comb
    begin
        if (capacity_reg == '0 || {1'b0, capacity_reg} > DEPTH_LIMIT)
        begin
            limit = DEPTH_LIMIT;
        end
        else
        begin
            limit = {1'b0, capacity_reg};
        end
    end

    assign full       = queue_full || !back_ready;
    assign queue_push = push && !full;

    always_comb
    begin
        queue_item.op_write    = operation;
        queue_item.addr_ok     = ({1'b0, address} < limit);
        queue_item.addr        = address[ADDR_W-1:0];
        queue_item.wdata       = write_data;
        queue_item.check_bit   = force_check_bit ? forced_bit_value : check_bit_of(write_data);
        queue_item.check_blank = blank_reg;
        queue_item.inhibit     = inhibit_reg;
    end

endmodule

[hw/rtl/cmpc_back.sv]
`include "core_memory_parity_checker_top_assert.svh"

module cmpc_back import cmpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_empty,
    input  mid_item_t mid_item,
    output logic      mid_pop,
    output logic      ready,
    input  logic      out_pop,
    output logic      out_empty,
    output result_t   out_item
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_READ  = 3'b100
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    mid_item_t         cur_reg;
    logic              inv_reg;
    logic              inv_next;
    logic              mc_reg;
    logic              mc_next;
    logic              stop_reg;
    logic              stop_next;

    logic [MEM_W-1:0]  mem [MEM_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [MEM_W-1:0]  rd_word_reg;
    logic              parity_bad;
    logic              check_read;

    result_t           out_slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] out_wr_ptr_reg;
    logic [QPTR_W-1:0] out_rd_ptr_reg;
    logic [QCNT_W-1:0] out_count_reg;
    logic [QCNT_W-1:0] out_count_next;
    logic              out_full;
    logic              out_push;
    result_t           out_result;

    assign ready      = (state_reg != ST_CLEAR);
    assign out_full   = (out_count_reg == QCNT_W'(QUEUE_DEPTH));
    assign out_empty  = (out_count_reg == '0);
    assign out_item   = out_slot_reg[out_rd_ptr_reg];
    assign parity_bad = (check_bit_of(rd_word_reg[DATA_W-1:0]) != rd_word_reg[CHECK_BIT]);
    assign check_read = rd_word_reg[MARK_BIT] || cur_reg.check_blank;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        inv_next      = inv_reg;
        mc_next       = mc_reg;
        stop_next     = stop_reg;
        mem_we        = 1'b0;
        mem_waddr     = mid_item.addr;
        mem_wdata     = {1'b1, mid_item.check_bit, mid_item.wdata};
        mem_re        = 1'b0;
        mid_pop       = 1'b0;
        out_push      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep zeroes the written marks after reset
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!mid_empty && !out_full)
                begin
                    mid_pop = 1'b1;
                    if (!mid_item.addr_ok)
                    begin
                        inv_next = 1'b1;
                        if (!mid_item.inhibit)
                        begin
                            stop_next = 1'b1;
                        end
                        out_push = 1'b1;
                    end
                    else
                    begin
                        inv_next = 1'b0;
                        if (mid_item.op_write)
                        begin
                            mem_we   = 1'b1;
                            out_push = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (check_read)
                begin
                    if (parity_bad)
                    begin
                        mc_next = 1'b1;
                        if (!cur_reg.inhibit)
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mc_next = 1'b0;
                    end
                end
                out_push   = 1'b1;
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_result.read_data            = (state_reg == ST_READ) ? rd_word_reg[DATA_W-1:0] : '0;
        out_result.invalid_address_lamp = inv_next;
        out_result.memory_check_lamp    = mc_next;
        out_result.stop_flag            = stop_next;
    end

    always_comb
    begin
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !out_push)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            inv_reg        <= 1'b0;
            mc_reg         <= 1'b0;
            stop_reg       <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            inv_reg       <= inv_next;
            mc_reg        <= mc_next;
            stop_reg      <= stop_next;
            out_count_reg <= out_count_next;
            if (out_push)
            begin
                out_wr_ptr_reg <= (out_wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : out_wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= (out_rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : out_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            cur_reg <= mid_item;
        end
        if (out_push)
        begin
            out_slot_reg[out_wr_ptr_reg] <= out_result;
        end
    end

    // marks, check bit and data share one word
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[mid_item.addr];
        end
    end

    `CMPC_ASSERT_NEVER(a_out_overflow, clk, rst_n, out_push && out_full, "result queue overflow")
    `CMPC_ASSERT_NEVER(a_stop_held, clk, rst_n, $fell(stop_reg), "stop flag dropped")
    `CMPC_ASSERT_NEXT(a_read_done, clk, rst_n, state_reg == ST_READ, state_reg == ST_RUN, "read late")

endmodule
